/* design/pdc_pkg.sv */
// Shared types, codes and constants of the Playfair digraph cipher block.
package pdc_pkg;

  localparam int SQUARE_SLOTS_DEF = 32;
  localparam int LETTER_W         = 5;
  localparam int JOBQ_DEPTH       = 4;
  localparam int RESQ_DEPTH       = 4;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 1;

  localparam logic [LETTER_W-1:0] FILLER_RU = 5'd26;
  localparam logic [LETTER_W-1:0] FILLER_EN = 5'd22;
  localparam logic [LETTER_W-1:0] LAST_RU   = 5'd31;
  localparam logic [LETTER_W-1:0] LAST_EN   = 5'd24;

  typedef enum logic [2:0] {
    CMD_KEY_CLEAR  = 3'd0,
    CMD_KEY_LETTER = 3'd1,
    CMD_KEY_DONE   = 3'd2,
    CMD_TEXT       = 3'd3,
    CMD_END        = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LANGUAGE = 1'b0,
    CFG_DECRYPT  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ODD    = 2'd1,
    ST_NO_KEY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    JOB_APPEND = 2'd0,
    JOB_PAIR   = 2'd1,
    JOB_MARK   = 2'd2
  } job_kind_t;

  typedef struct packed {
    logic [2:0]          command;
    logic [LETTER_W-1:0] letter;
  } in_item_t;

  typedef struct packed {
    logic [LETTER_W-1:0] out_letter;
    logic                letter_valid;
    logic                last;
    logic [1:0]          status;
  } out_item_t;

  typedef struct packed {
    logic language;
    logic decrypt_mode;
  } cfg_t;

  // For an append, a is the letter and b the square slot it goes to.
  typedef struct packed {
    job_kind_t           kind;
    logic [LETTER_W-1:0] a;
    logic [LETTER_W-1:0] b;
    logic                last;
    logic [1:0]          status;
  } job_t;

endpackage

/* design/playfair_digraph_cipher_top.sv */
// Top level of the Playfair digraph cipher block.
// The block takes one request per cycle while its job queue has room, and a text letter
// passes through the job queue and the back-end pipeline into the result queue; a
// completed pair leaves as two results, first letter then second, through the result
// queue, so sustained throughput is about one request per cycle and two result writes
// per cipher pair, set by the single result write port. A key letter that directly
// follows a text result waits in the back end while that result is in the first stage.
// Key done is the exception: it completes the square by stepping through the alphabet
// one letter per cycle while the job queue has room, during which full stays high.
// Configuration writes take effect at the next edge and must only be made while no
// request is in flight; changing the language clears the key, changing the mode clears
// any half-formed pair.
module playfair_digraph_cipher_top
  import pdc_pkg::*;
#(
  parameter int SQUARE_SLOTS = SQUARE_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_data,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  logic      job_push, job_full, job_empty, job_pop;
  job_t      job_in, job_head;
  logic      res_push, res_full;
  out_item_t res_data;

  pdc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .job_push  (job_push),
    .job       (job_in),
    .job_full  (job_full)
  );

  pdc_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOBQ_DEPTH)
  ) u_job_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (job_push),
    .wr_data    (job_in),
    .fifo_full  (job_full),
    .rd_en      (job_pop),
    .rd_data    (job_head),
    .fifo_empty (job_empty)
  );

  pdc_back #(
    .SQUARE_SLOTS (SQUARE_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job_empty (job_empty),
    .job_head  (job_head),
    .job_pop   (job_pop),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_full  (res_full)
  );

  pdc_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (RESQ_DEPTH)
  ) u_res_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (res_push),
    .wr_data    (res_data),
    .fifo_full  (res_full),
    .rd_en      (pop),
    .rd_data    (out_data),
    .fifo_empty (empty)
  );

endmodule

/* design/pdc_fifo.sv */
// Small register-based first-in first-out queue.
module pdc_fifo
  import pdc_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             fifo_full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             fifo_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign fifo_full  = (count_r == CNT_W'(DEPTH));
  assign fifo_empty = (count_r == '0);
  assign do_wr      = wr_en && !fifo_full;
  assign do_rd      = rd_en && !fifo_empty;
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* design/pdc_front.sv */
// Front end: configuration, command decoding, key bookkeeping and text pairing.
module pdc_front
  import pdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg,
  output logic                  job_push,
  output job_t                  job,
  input  logic                  job_full
);

  logic                lang_r, lang_nxt, dec_r, dec_nxt;
  logic [31:0]         used_r, used_nxt;
  logic [5:0]          fill_r, fill_nxt;
  logic                key_ready_r, key_ready_nxt;
  logic [LETTER_W-1:0] prev_r, prev_nxt, pend_r, pend_nxt;
  logic                prev_v_r, prev_v_nxt, pend_v_r, pend_v_nxt;
  logic                sweep_r, sweep_nxt;
  logic [LETTER_W-1:0] idx_r, idx_nxt;

  logic                accept;
  logic [LETTER_W-1:0] alpha_last, filler, l;
  logic                in_alpha, dbl;

  assign full       = sweep_r || job_full;
  assign accept     = push && !full;
  assign cfg        = '{language: lang_r, decrypt_mode: dec_r};
  assign alpha_last = lang_r ? LAST_EN : LAST_RU;
  assign filler     = lang_r ? FILLER_EN : FILLER_RU;
  assign l          = in_data.letter;
  assign in_alpha   = (l <= alpha_last);
  assign dbl        = !dec_r && prev_v_r && (prev_r == l);

  always_comb begin
    lang_nxt      = lang_r;
    dec_nxt       = dec_r;
    used_nxt      = used_r;
    fill_nxt      = fill_r;
    key_ready_nxt = key_ready_r;
    prev_nxt      = prev_r;
    prev_v_nxt    = prev_v_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    sweep_nxt     = sweep_r;
    idx_nxt       = idx_r;
    job_push      = 1'b0;
    job           = '0;

    if (sweep_r) begin
      // Completion of the key: one alphabet letter is examined per cycle while the job queue has room.
      if (!job_full) begin
        if (!used_r[idx_r]) begin
          job_push = 1'b1;
          job.kind = JOB_APPEND;
          job.a    = idx_r;
          job.b    = fill_r[LETTER_W-1:0];
          fill_nxt = fill_r + 1'b1;
        end
        if (idx_r == alpha_last) begin
          sweep_nxt     = 1'b0;
          key_ready_nxt = 1'b1;
          prev_v_nxt    = 1'b0;
          pend_v_nxt    = 1'b0;
          prev_nxt      = '0;
          pend_nxt      = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
    end else if (accept) begin
      unique case (in_data.command)
        CMD_KEY_CLEAR: begin
          used_nxt      = '0;
          fill_nxt      = '0;
          key_ready_nxt = 1'b0;
          prev_v_nxt    = 1'b0;
          pend_v_nxt    = 1'b0;
          prev_nxt      = '0;
          pend_nxt      = '0;
        end
        CMD_KEY_LETTER: begin
          if (!key_ready_r && in_alpha && !used_r[l]) begin
            job_push    = 1'b1;
            job.kind    = JOB_APPEND;
            job.a       = l;
            job.b       = fill_r[LETTER_W-1:0];
            used_nxt[l] = 1'b1;
            fill_nxt    = fill_r + 1'b1;
          end
        end
        CMD_KEY_DONE: begin
          if (!key_ready_r) begin
            sweep_nxt = 1'b1;
            idx_nxt   = '0;
          end
        end
        CMD_TEXT: begin
          if (in_alpha) begin
            if (!key_ready_r) begin
              job_push   = 1'b1;
              job.kind   = JOB_MARK;
              job.status = ST_NO_KEY;
            end else begin
              if (dbl) begin
                // The filler goes between two equal letters; one pair results
                // either way, with the letter left over or consumed.
                job_push = 1'b1;
                job.kind = JOB_PAIR;
                if (pend_v_r) begin
                  job.a      = pend_r;
                  job.b      = filler;
                  pend_nxt   = l;
                  pend_v_nxt = 1'b1;
                end else begin
                  job.a      = filler;
                  job.b      = l;
                  pend_v_nxt = 1'b0;
                end
              end else if (pend_v_r) begin
                job_push   = 1'b1;
                job.kind   = JOB_PAIR;
                job.a      = pend_r;
                job.b      = l;
                pend_v_nxt = 1'b0;
              end else begin
                pend_nxt   = l;
                pend_v_nxt = 1'b1;
              end
              prev_nxt   = l;
              prev_v_nxt = 1'b1;
            end
          end
        end
        CMD_END: begin
          job_push = 1'b1;
          job.last = 1'b1;
          if (!key_ready_r) begin
            job.kind   = JOB_MARK;
            job.status = ST_NO_KEY;
          end else if (!pend_v_r) begin
            job.kind   = JOB_MARK;
            job.status = ST_OK;
          end else if (dec_r) begin
            job.kind   = JOB_MARK;
            job.status = ST_ODD;
          end else begin
            job.kind = JOB_PAIR;
            job.a    = pend_r;
            job.b    = filler;
          end
          prev_v_nxt = 1'b0;
          pend_v_nxt = 1'b0;
          prev_nxt   = '0;
          pend_nxt   = '0;
        end
        default: begin
        end
      endcase
    end

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_LANGUAGE: begin
          if (cfg_wdata[0] != lang_r) begin
            lang_nxt      = cfg_wdata[0];
            used_nxt      = '0;
            fill_nxt      = '0;
            key_ready_nxt = 1'b0;
            sweep_nxt     = 1'b0;
            prev_v_nxt    = 1'b0;
            pend_v_nxt    = 1'b0;
            prev_nxt      = '0;
            pend_nxt      = '0;
          end
        end
        CFG_DECRYPT: begin
          if (cfg_wdata[0] != dec_r) begin
            dec_nxt    = cfg_wdata[0];
            prev_v_nxt = 1'b0;
            pend_v_nxt = 1'b0;
            prev_nxt   = '0;
            pend_nxt   = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lang_r      <= 1'b0;
      dec_r       <= 1'b0;
      used_r      <= '0;
      fill_r      <= '0;
      key_ready_r <= 1'b0;
      prev_r      <= '0;
      prev_v_r    <= 1'b0;
      pend_r      <= '0;
      pend_v_r    <= 1'b0;
      sweep_r     <= 1'b0;
      idx_r       <= '0;
    end else begin
      lang_r      <= lang_nxt;
      dec_r       <= dec_nxt;
      used_r      <= used_nxt;
      fill_r      <= fill_nxt;
      key_ready_r <= key_ready_nxt;
      prev_r      <= prev_nxt;
      prev_v_r    <= prev_v_nxt;
      pend_r      <= pend_nxt;
      pend_v_r    <= pend_v_nxt;
      sweep_r     <= sweep_nxt;
      idx_r       <= idx_nxt;
    end
  end

endmodule

/* design/pdc_back.sv */
// Back end: key square and position memories, pair lookup pipeline and result emission.
module pdc_back
  import pdc_pkg::*;
#(
  parameter int SQUARE_SLOTS = SQUARE_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      job_empty,
  input  job_t      job_head,
  output logic      job_pop,
  output logic      res_push,
  output out_item_t res_data,
  input  logic      res_full
);

  logic [LETTER_W-1:0] pos_mem [32];
  logic [LETTER_W-1:0] sq_mem  [SQUARE_SLOTS];

  logic                v1_r, v2_r, v3_r, second_r;
  job_t                job1_r, job2_r, job3_r;
  logic [LETTER_W-1:0] pa_r, pb_r, oa_r, ob_r, sa_r, sb_r;
  logic                oa_ok_r, ob_ok_r, sa_ok_r, sb_ok_r;
  logic                adv, emit_last, take_job;

  logic [2:0]          r1, c1, r2, c2, rows_m1, cols_m1;
  logic [2:0]          r1n, c1n, r2n, c2n;
  logic [LETTER_W-1:0] oa, ob;

  function automatic logic [2:0] row_of(input logic [LETTER_W-1:0] p, input logic en);
    logic [8:0] prod;
    begin
      // p / 5 for any five-bit p, by multiplying with 13/64; p / 4 for Russian.
      prod = {4'b0, p} * 9'd13;
      row_of = en ? prod[8:6] : p[4:2];
    end
  endfunction

  function automatic logic [2:0] col_of(input logic [LETTER_W-1:0] p, input logic en,
                                        input logic [2:0] row);
    logic [5:0] r5;
    begin
      r5 = ({3'b0, row} << 2) + {3'b0, row};
      col_of = en ? 3'(({1'b0, p} - r5)) : {1'b0, p[1:0]};
    end
  endfunction

  function automatic logic [LETTER_W-1:0] slot_of(input logic [2:0] row, input logic [2:0] col,
                                                  input logic en);
    logic [5:0] s5;
    begin
      s5 = ({3'b0, row} << 2) + {3'b0, row} + {3'b0, col};
      slot_of = en ? s5[LETTER_W-1:0] : {row, col[1:0]};
    end
  endfunction

  function automatic logic [2:0] step(input logic [2:0] v, input logic [2:0] top,
                                      input logic back);
    begin
      if (back) begin
        step = (v == 3'd0) ? top : v - 1'b1;
      end else begin
        step = (v == top) ? 3'd0 : v + 1'b1;
      end
    end
  endfunction

  assign emit_last = v3_r && !res_full && ((job3_r.kind != JOB_PAIR) || second_r);
  assign adv       = !v3_r || emit_last;
  // An append waits while a request sits in the first stage, as that request still has
  // to read the square as it was before the append.
  assign take_job  = adv && !job_empty && !(v1_r && (job_head.kind == JOB_APPEND));
  assign job_pop   = take_job;

  // Square memories are written when an append leaves the queue.
  always_ff @(posedge clk) begin
    if (take_job && (job_head.kind == JOB_APPEND)) begin
      pos_mem[job_head.a] <= job_head.b;
      if (int'(job_head.b) < SQUARE_SLOTS) begin
        sq_mem[job_head.b] <= job_head.a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_job) begin
      job1_r <= job_head;
      pa_r   <= pos_mem[job_head.a];
      pb_r   <= pos_mem[job_head.b];
    end
  end

  always_comb begin
    cols_m1 = cfg.language ? 3'd4 : 3'd3;
    rows_m1 = cfg.language ? 3'd4 : 3'd7;
    r1  = row_of(pa_r, cfg.language);
    r2  = row_of(pb_r, cfg.language);
    c1  = col_of(pa_r, cfg.language, r1);
    c2  = col_of(pb_r, cfg.language, r2);
    r1n = step(r1, rows_m1, cfg.decrypt_mode);
    r2n = step(r2, rows_m1, cfg.decrypt_mode);
    c1n = step(c1, cols_m1, cfg.decrypt_mode);
    c2n = step(c2, cols_m1, cfg.decrypt_mode);
    if (r1 == r2) begin
      oa = slot_of(r1, c1n, cfg.language);
      ob = slot_of(r2, c2n, cfg.language);
    end else if (c1 == c2) begin
      oa = slot_of(r1n, c1, cfg.language);
      ob = slot_of(r2n, c2, cfg.language);
    end else begin
      oa = slot_of(r1, c2, cfg.language);
      ob = slot_of(r2, c1, cfg.language);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      job2_r  <= job1_r;
      oa_r    <= oa;
      ob_r    <= ob;
      oa_ok_r <= (int'(oa) < SQUARE_SLOTS);
      ob_ok_r <= (int'(ob) < SQUARE_SLOTS);
      job3_r  <= job2_r;
      sa_r    <= sq_mem[oa_r];
      sb_r    <= sq_mem[ob_r];
      sa_ok_r <= oa_ok_r;
      sb_ok_r <= ob_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      second_r <= 1'b0;
    end else if (adv) begin
      v1_r     <= take_job && (job_head.kind != JOB_APPEND);
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      second_r <= 1'b0;
    end else if (res_push) begin
      second_r <= 1'b1;
    end
  end

  always_comb begin
    res_push = v3_r && !res_full;
    res_data = '0;
    if (job3_r.kind == JOB_PAIR) begin
      res_data.letter_valid = 1'b1;
      if (second_r) begin
        res_data.out_letter = sb_ok_r ? sb_r : '0;
        res_data.last       = job3_r.last;
      end else begin
        res_data.out_letter = sa_ok_r ? sa_r : '0;
      end
    end else begin
      res_data.last   = job3_r.last;
      res_data.status = job3_r.status;
    end
  end

endmodule
